// ----- sv/slpr_pkg.sv -----
package slpr_pkg;

    localparam int STAT_W     = 3;
    localparam int NOW_W      = 32;
    localparam int PER_W      = 16;
    localparam int LVL_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 4;
    localparam int NUM2_W     = PER_W + LVL_W;
    localparam int SLOT_W     = 3;

    localparam logic [LVL_W-1:0] LEVEL_FULL = 8'd255;

    typedef enum logic [STAT_W-1:0] {
        ST_IDLE  = 3'd0,
        ST_BUSY  = 3'd1,
        ST_WAIT  = 3'd2,
        ST_ERROR = 3'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUSY_PERIOD  = 3'd0,
        CFG_WAIT_ESC     = 3'd1,
        CFG_WAIT_BLINK   = 3'd2,
        CFG_ERROR_PERIOD = 3'd3,
        CFG_FLICK_STEP   = 3'd4,
        CFG_IDLE_LEVEL   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_FLICK,
        K_IDLE,
        K_BUSY,
        K_STEADY,
        K_BLINK,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [LVL_W-1:0]  lvl;
        logic [NOW_W-1:0]  now;
        logic [PER_W-1:0]  per;
    } t_job;

    typedef struct packed {
        t_kind             kind;
        logic [LVL_W-1:0]  lvl;
        logic [PER_W-1:0]  per;
    } t_tag1;

    typedef struct packed {
        t_kind              kind;
        logic [LVL_W-1:0]   lvl;
        logic [SLOT_W-1:0]  slot;
        logic               sq;
    } t_tag2;

    function automatic logic [LVL_W-1:0] amber_yellow(input logic [SLOT_W-1:0] s);
        logic [LVL_W-1:0] v;
        case (s)
            3'd0: v = 8'd255;
            3'd1: v = 8'd40;
            3'd2: v = 8'd180;
            3'd3: v = 8'd20;
            3'd4: v = 8'd90;
            3'd5: v = 8'd255;
            3'd6: v = 8'd10;
            default: v = 8'd140;
        endcase
        return v;
    endfunction

    function automatic logic [LVL_W-1:0] amber_red(input logic [SLOT_W-1:0] s);
        logic [LVL_W-1:0] v;
        case (s)
            3'd0: v = 8'd60;
            3'd1: v = 8'd200;
            3'd2: v = 8'd30;
            3'd3: v = 8'd255;
            3'd4: v = 8'd15;
            3'd5: v = 8'd120;
            3'd6: v = 8'd220;
            default: v = 8'd45;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/status_lamp_pattern_render_top.sv -----
// Channel   Direction  Handshake            Payload
// request   in         push / full          i_status, i_linked, i_now_time, i_status_start
// result    out        empty / pop          o_green_level, o_yellow_level, o_red_level
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request is taken per cycle and one result leaves per cycle when pop keeps up.
// A request passes one front stage, the queue, a 32-step time divider,
// one ramp stage, a 24-step ramp divider and the result register.
// Reset is synchronous; it clears every valid flag and sets the configuration to its defaults.
// A held result stalls the whole back pipeline; the front queue then fills and full rises.
module status_lamp_pattern_render_top #(
    parameter int Q_DEPTH = slpr_pkg::Q_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [slpr_pkg::STAT_W-1:0]     i_status,
    input  logic                            i_linked,
    input  logic [slpr_pkg::NOW_W-1:0]      i_now_time,
    input  logic [slpr_pkg::NOW_W-1:0]      i_status_start,
    output logic                            empty,
    input  logic                            pop,
    output logic [slpr_pkg::LVL_W-1:0]      o_green_level,
    output logic [slpr_pkg::LVL_W-1:0]      o_yellow_level,
    output logic [slpr_pkg::LVL_W-1:0]      o_red_level,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [slpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slpr_pkg::*;

    logic w_f_v;
    t_job w_f_job;
    logic w_q_ready;
    logic w_q_v;
    t_job w_q_job;
    logic w_take;

    assign o_cfg_ready = 1'b1;

    slpr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .full           (full),
        .i_status       (i_status),
        .i_linked       (i_linked),
        .i_now_time     (i_now_time),
        .i_status_start (i_status_start),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_job_v        (w_f_v),
        .o_job          (w_f_job),
        .i_job_ready    (w_q_ready)
    );

    slpr_queue #(.DEPTH(Q_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_f_v),
        .o_wr_ready (w_q_ready),
        .i_data     (w_f_job),
        .i_rd       (w_take),
        .o_rd_v     (w_q_v),
        .o_data     (w_q_job)
    );

    slpr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_v        (w_q_v),
        .i_job          (w_q_job),
        .o_job_take     (w_take),
        .empty          (empty),
        .pop            (pop),
        .o_green_level  (o_green_level),
        .o_yellow_level (o_yellow_level),
        .o_red_level    (o_red_level)
    );

endmodule

// ----- sv/slpr_front.sv -----
module slpr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           full,
    input  logic [slpr_pkg::STAT_W-1:0]    i_status,
    input  logic                           i_linked,
    input  logic [slpr_pkg::NOW_W-1:0]     i_now_time,
    input  logic [slpr_pkg::NOW_W-1:0]     i_status_start,
    input  logic                           i_cfg_valid,
    input  logic [slpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_job_v,
    output slpr_pkg::t_job                 o_job,
    input  logic                           i_job_ready
);
    import slpr_pkg::*;

    logic [PER_W-1:0] r_busy_per;
    logic [NOW_W-1:0] r_wait_esc;
    logic [PER_W-1:0] r_wait_blink;
    logic [PER_W-1:0] r_err_per;
    logic [PER_W-1:0] r_flick_step;
    logic [LVL_W-1:0] r_idle_lvl;

    logic             r_v;
    t_job             r_job;
    t_job             n_job;
    logic [NOW_W-1:0] w_elapsed;
    logic             w_adv;

    function automatic logic [PER_W-1:0] min_two(input logic [PER_W-1:0] p);
        return (p < PER_W'(2)) ? PER_W'(2) : p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_per   <= PER_W'(2000);
            r_wait_esc   <= NOW_W'(30000);
            r_wait_blink <= PER_W'(1000);
            r_err_per    <= PER_W'(250);
            r_flick_step <= PER_W'(70);
            r_idle_lvl   <= LVL_W'(40);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUSY_PERIOD:  r_busy_per   <= i_cfg_data[PER_W-1:0];
                CFG_WAIT_ESC:     r_wait_esc   <= i_cfg_data[NOW_W-1:0];
                CFG_WAIT_BLINK:   r_wait_blink <= i_cfg_data[PER_W-1:0];
                CFG_ERROR_PERIOD: r_err_per    <= i_cfg_data[PER_W-1:0];
                CFG_FLICK_STEP:   r_flick_step <= i_cfg_data[PER_W-1:0];
                CFG_IDLE_LEVEL:   r_idle_lvl   <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_elapsed = i_now_time - i_status_start;

    always_comb begin
        n_job.now = i_now_time;
        n_job.lvl = r_idle_lvl;
        if (!i_linked || i_status > ST_ERROR) begin
            n_job.kind = K_FLICK;
        end else begin
            case (i_status)
                ST_IDLE: n_job.kind = K_IDLE;
                ST_BUSY: n_job.kind = K_BUSY;
                ST_WAIT: n_job.kind = (w_elapsed >= r_wait_esc) ? K_BLINK : K_STEADY;
                default: n_job.kind = K_ERROR;
            endcase
        end
        case (n_job.kind)
            K_FLICK: n_job.per = (r_flick_step == '0) ? PER_W'(1) : r_flick_step;
            K_BUSY:  n_job.per = min_two(r_busy_per);
            K_BLINK: n_job.per = min_two(r_wait_blink);
            K_ERROR: n_job.per = min_two(r_err_per);
            default: n_job.per = PER_W'(2);
        endcase
    end

    assign w_adv = !r_v || i_job_ready;
    assign full  = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_push;
        end
        if (w_adv) begin
            r_job <= n_job;
        end
    end

    assign o_job_v = r_v;
    assign o_job   = r_job;

endmodule

// ----- sv/slpr_queue.sv -----
module slpr_queue #(
    parameter int DEPTH = slpr_pkg::Q_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    output logic           o_wr_ready,
    input  slpr_pkg::t_job i_data,
    input  logic           i_rd,
    output logic           o_rd_v,
    output slpr_pkg::t_job o_data
);
    import slpr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_v     = (r_cnt != '0);
    assign w_wr       = i_wr && o_wr_ready;
    assign w_rd       = i_rd && o_rd_v;
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- sv/slpr_div.sv -----
module slpr_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_v,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [TW-1:0] o_tag
);

    logic          w_v   [NW+1];
    logic [DW-1:0] w_rem [NW+1];
    logic [NW-1:0] w_nq  [NW+1];
    logic [DW-1:0] w_den [NW+1];
    logic [TW-1:0] w_tag [NW+1];

    assign w_v[0]   = i_v;
    assign w_rem[0] = '0;
    assign w_nq[0]  = i_num;
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          r_v;
        logic [DW-1:0] r_rem;
        logic [NW-1:0] r_nq;
        logic [DW-1:0] r_den;
        logic [TW-1:0] r_tag;
        logic [DW:0]   w_sh;
        logic [DW+1:0] w_trial;
        logic [NW-1:0] w_shq;

        assign w_sh    = {w_rem[k], w_nq[k][NW-1]};
        assign w_trial = {1'b0, w_sh} - {2'b00, w_den[k]};
        assign w_shq   = w_nq[k] << 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
            if (i_en) begin
                r_den <= w_den[k];
                r_tag <= w_tag[k];
                if (!w_trial[DW+1]) begin
                    r_rem <= w_trial[DW-1:0];
                    r_nq  <= w_shq | NW'(1);
                end else begin
                    r_rem <= w_sh[DW-1:0];
                    r_nq  <= w_shq;
                end
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_rem[k+1] = r_rem;
        assign w_nq[k+1]  = r_nq;
        assign w_den[k+1] = r_den;
        assign w_tag[k+1] = r_tag;
    end

    assign o_v   = w_v[NW];
    assign o_quo = w_nq[NW];
    assign o_rem = w_rem[NW];
    assign o_tag = w_tag[NW];

endmodule

// ----- sv/slpr_back.sv -----
module slpr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_v,
    input  slpr_pkg::t_job             i_job,
    output logic                       o_job_take,
    output logic                       empty,
    input  logic                       pop,
    output logic [slpr_pkg::LVL_W-1:0] o_green_level,
    output logic [slpr_pkg::LVL_W-1:0] o_yellow_level,
    output logic [slpr_pkg::LVL_W-1:0] o_red_level
);
    import slpr_pkg::*;

    logic              w_en;
    t_tag1             w_tag1_in;
    logic              w_d1_v;
    logic [NOW_W-1:0]  w_d1_quo;
    logic [PER_W-1:0]  w_d1_rem;
    logic [$bits(t_tag1)-1:0] w_d1_tag;
    t_tag1             w_t1;

    logic [PER_W-1:0]  w_half;
    logic              w_lt;
    logic [PER_W-1:0]  w_x;
    logic [NUM2_W-1:0] w_num2;
    t_tag2             n_m_tag;

    logic              r_m_v;
    logic [NUM2_W-1:0] r_m_num;
    logic [PER_W-1:0]  r_m_half;
    t_tag2             r_m_tag;

    logic              w_d2_v;
    logic [NUM2_W-1:0] w_d2_quo;
    logic [PER_W-1:0]  w_d2_rem;
    logic [$bits(t_tag2)-1:0] w_d2_tag;
    t_tag2             w_t2;

    logic              r_out_v;
    logic [LVL_W-1:0]  r_g;
    logic [LVL_W-1:0]  r_y;
    logic [LVL_W-1:0]  r_r;
    logic [LVL_W-1:0]  n_g;
    logic [LVL_W-1:0]  n_y;
    logic [LVL_W-1:0]  n_r;

    assign w_en       = !r_out_v || pop;
    assign o_job_take = w_en;

    assign w_tag1_in.kind = i_job.kind;
    assign w_tag1_in.lvl  = i_job.lvl;
    assign w_tag1_in.per  = i_job.per;

    slpr_div #(.NW(NOW_W), .DW(PER_W), .TW($bits(t_tag1))) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (i_job_v),
        .i_num   (i_job.now),
        .i_den   (i_job.per),
        .i_tag   (w_tag1_in),
        .o_v     (w_d1_v),
        .o_quo   (w_d1_quo),
        .o_rem   (w_d1_rem),
        .o_tag   (w_d1_tag)
    );

    assign w_t1   = t_tag1'(w_d1_tag);
    assign w_half = w_t1.per >> 1;
    assign w_lt   = (w_d1_rem < w_half);
    assign w_x    = w_lt ? w_d1_rem : (w_t1.per - w_d1_rem);
    assign w_num2 = {w_x, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, w_x};

    always_comb begin
        n_m_tag.kind = w_t1.kind;
        n_m_tag.lvl  = w_t1.lvl;
        n_m_tag.slot = w_d1_quo[SLOT_W-1:0];
        n_m_tag.sq   = w_lt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_d1_v;
        end
        if (w_en) begin
            r_m_num  <= w_num2;
            r_m_half <= w_half;
            r_m_tag  <= n_m_tag;
        end
    end

    slpr_div #(.NW(NUM2_W), .DW(PER_W), .TW($bits(t_tag2))) u_div_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (r_m_v),
        .i_num   (r_m_num),
        .i_den   (r_m_half),
        .i_tag   (r_m_tag),
        .o_v     (w_d2_v),
        .o_quo   (w_d2_quo),
        .o_rem   (w_d2_rem),
        .o_tag   (w_d2_tag)
    );

    assign w_t2 = t_tag2'(w_d2_tag);

    always_comb begin
        n_g = '0;
        n_y = '0;
        n_r = '0;
        case (w_t2.kind)
            K_FLICK: begin
                n_y = amber_yellow(w_t2.slot);
                n_r = amber_red(w_t2.slot);
            end
            K_IDLE:   n_g = w_t2.lvl;
            K_BUSY:   n_y = (w_d2_quo > NUM2_W'(LEVEL_FULL)) ? LEVEL_FULL
                                                             : w_d2_quo[LVL_W-1:0];
            K_STEADY: n_r = LEVEL_FULL;
            K_BLINK:  n_r = w_t2.sq ? LEVEL_FULL : '0;
            default: begin
                if (w_t2.sq) begin
                    n_r = LEVEL_FULL;
                end else begin
                    n_y = LEVEL_FULL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
        if (w_en) begin
            r_g <= n_g;
            r_y <= n_y;
            r_r <= (w_d2_rem == w_d2_rem) ? n_r : '0;
        end
    end

    assign empty          = !r_out_v;
    assign o_green_level  = r_g;
    assign o_yellow_level = r_y;
    assign o_red_level    = r_r;

endmodule

// ----- sv/slpr_checker.sv -----
module slpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_green_level,
    input logic [7:0] o_yellow_level,
    input logic [7:0] o_red_level
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue flags not clear after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_green_level)
                              && $stable(o_yellow_level) && $stable(o_red_level)))
        else $error("stalled result changed");

    a_green_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_green_level != 8'd0) |-> (o_yellow_level == 8'd0 && o_red_level == 8'd0))
        else $error("green lit together with another lamp");

    a_no_double_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_yellow_level == 8'd255 && o_red_level == 8'd255))
        else $error("red and yellow both at full level");

endmodule

bind status_lamp_pattern_render_top slpr_checker u_slpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_green_level  (o_green_level),
    .o_yellow_level (o_yellow_level),
    .o_red_level    (o_red_level)
);

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slpr_pkg::*;

    localparam int LATENCY = 80;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] yellow;
        logic [LVL_W-1:0] red;
    } t_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [STAT_W-1:0]     i_status = '0;
    logic                  i_linked = 1'b0;
    logic [NOW_W-1:0]      i_now_time = '0;
    logic [NOW_W-1:0]      i_status_start = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [LVL_W-1:0]      o_green_level;
    logic [LVL_W-1:0]      o_yellow_level;
    logic [LVL_W-1:0]      o_red_level;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [31:0] busy_period;
    logic [31:0] escalate_limit;
    logic [31:0] blink_period;
    logic [31:0] error_period;
    logic [31:0] flicker_step;
    logic [31:0] green_idle;

    t_frame expected_frames[$];
    int     error_count = 0;
    int     quiet_cycles = 0;
    int     idle_pct = 22;

    status_lamp_pattern_render_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] at_least_two(input logic [31:0] p);
        return p < 2 ? 32'd2 : p;
    endfunction

    function automatic logic [LVL_W-1:0] ramp_level(input logic [31:0] t,
                                                    input logic [31:0] per);
        logic [31:0] p;
        logic [31:0] phase;
        logic [31:0] half;
        logic [63:0] v;
        p = at_least_two(per);
        phase = t % p;
        half = p / 2;
        if (phase < half) begin
            v = (64'(phase) * 255) / half;
        end else begin
            v = (64'(p - phase) * 255) / half;
        end
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    function automatic logic square_on(input logic [31:0] t, input logic [31:0] per);
        logic [31:0] p;
        p = at_least_two(per);
        return (t % p) < (p / 2);
    endfunction

    function automatic t_frame render_frame(input logic [2:0] st, input logic lk,
                                            input logic [31:0] t, input logic [31:0] t0);
        t_frame f;
        logic [31:0] stp;
        logic [2:0] slot;
        logic [7:0] ytab[8];
        logic [7:0] rtab[8];
        ytab = '{8'd255, 8'd40, 8'd180, 8'd20, 8'd90, 8'd255, 8'd10, 8'd140};
        rtab = '{8'd60, 8'd200, 8'd30, 8'd255, 8'd15, 8'd120, 8'd220, 8'd45};
        f.green = '0;
        f.yellow = '0;
        f.red = '0;
        if (!lk || st > ST_ERROR) begin
            stp = flicker_step == 0 ? 32'd1 : flicker_step;
            slot = 3'((t / stp) % 8);
            f.yellow = ytab[slot];
            f.red = rtab[slot];
        end else if (st == ST_IDLE) begin
            f.green = green_idle[7:0];
        end else if (st == ST_BUSY) begin
            f.yellow = ramp_level(t, busy_period);
        end else if (st == ST_WAIT) begin
            if (t - t0 >= escalate_limit) begin
                f.red = square_on(t, blink_period) ? LEVEL_FULL : 8'd0;
            end else begin
                f.red = LEVEL_FULL;
            end
        end else begin
            if (square_on(t, error_period)) begin
                f.red = LEVEL_FULL;
            end else begin
                f.yellow = LEVEL_FULL;
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if ((push && !full) || (i_cfg_valid && o_cfg_ready) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (pop && !empty && i_rst_n) begin
            t_frame f;
            if (expected_frames.size() == 0) begin
                report_mismatch("result count", 8'd1, 8'd0);
            end else begin
                f = expected_frames.pop_front();
                if (o_green_level !== f.green) begin
                    report_mismatch("green", o_green_level, f.green);
                end
                if (o_yellow_level !== f.yellow) begin
                    report_mismatch("yellow", o_yellow_level, f.yellow);
                end
                if (o_red_level !== f.red) begin
                    report_mismatch("red", o_red_level, f.red);
                end
            end
        end
        pop <= ($urandom_range(99) >= idle_pct);
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_frame(input logic [2:0] st, input logic lk,
                              input logic [31:0] t, input logic [31:0] t0);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_status <= st;
        i_linked <= lk;
        i_now_time <= t;
        i_status_start <= t0;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_frames.push_back(render_frame(st, lk, t, t0));
    endtask

    task automatic drain_pipeline();
        push <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BUSY_PERIOD:  busy_period = value[15:0];
            CFG_WAIT_ESC:     escalate_limit = value;
            CFG_WAIT_BLINK:   blink_period = value[15:0];
            CFG_ERROR_PERIOD: error_period = value[15:0];
            CFG_FLICK_STEP:   flicker_step = value[15:0];
            default:          green_idle = value[7:0];
        endcase
    endtask

    task automatic configure_all(input logic [31:0] bp, input logic [31:0] esc,
                                 input logic [31:0] bl, input logic [31:0] ep,
                                 input logic [31:0] fs, input logic [31:0] lvl);
        drain_pipeline();
        write_register(CFG_BUSY_PERIOD, bp);
        write_register(CFG_WAIT_ESC, esc);
        write_register(CFG_WAIT_BLINK, bl);
        write_register(CFG_ERROR_PERIOD, ep);
        write_register(CFG_FLICK_STEP, fs);
        write_register(CFG_IDLE_LEVEL, lvl);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_patterns();
        send_frame(ST_IDLE, 1'b1, 32'd0, 32'd0);
        send_frame(ST_IDLE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(ST_BUSY, 1'b1, 32'd0, 32'd0);
        send_frame(ST_BUSY, 1'b1, 32'd999, 32'd0);
        send_frame(ST_BUSY, 1'b1, 32'd1000, 32'd0);
        send_frame(ST_BUSY, 1'b1, 32'hFFFF_FFFF, 32'd0);
        send_frame(ST_WAIT, 1'b1, 32'd29999, 32'd0);
        send_frame(ST_WAIT, 1'b1, 32'd30000, 32'd0);
        send_frame(ST_WAIT, 1'b1, 32'd30500, 32'd0);
        send_frame(ST_WAIT, 1'b1, 32'd10, 32'hFFFF_FFF0);
        send_frame(ST_WAIT, 1'b1, 32'd0, 32'd1);
        send_frame(ST_ERROR, 1'b1, 32'd124, 32'd0);
        send_frame(ST_ERROR, 1'b1, 32'd125, 32'd0);
        for (int s = 0; s < 8; s++) begin
            send_frame(3'(s), 1'b0, 32'(s * 70), 32'd0);
        end
        send_frame(3'd4, 1'b1, 32'd140, 32'd0);
        send_frame(3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_extreme_settings();
        configure_all(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd255);
        for (int k = 0; k < 12; k++) begin
            send_frame(3'(k % 5), 1'(k != 4), 32'(k), 32'd0);
        end
        configure_all(32'd3, 32'hFFFF_FFFF, 32'd3, 32'd3, 32'd1, 32'd0);
        for (int k = 0; k < 12; k++) begin
            send_frame(3'(k % 4), 1'b1, 32'(k), 32'(k + 1 - (k % 2) * 2));
        end
        configure_all(32'hFFFF, 32'd1, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd128);
        for (int k = 0; k < 12; k++) begin
            send_frame(3'(k % 4), 1'(k < 10), $urandom, $urandom);
        end
    endtask

    task automatic test_random_frames(input int count);
        logic [31:0] t;
        logic [31:0] t0;
        for (int k = 0; k < count; k++) begin
            t = $urandom;
            if ($urandom_range(3) == 0) t = $urandom_range(70000);
            t0 = ($urandom_range(1) == 0) ? $urandom : t - $urandom_range(70000);
            send_frame(3'($urandom_range(9) < 8 ? $urandom_range(3) : $urandom_range(7)),
                       1'($urandom_range(9) != 0), t, t0);
        end
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++) begin
            configure_all($urandom_range(65535),
                          $urandom_range(1) ? $urandom : $urandom_range(70000),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(1) ? $urandom_range(65535) : $urandom_range(200),
                          $urandom_range(255));
            test_random_frames(300);
        end
    endtask

    initial begin
        busy_period = 2000;
        escalate_limit = 30000;
        blink_period = 1000;
        error_period = 250;
        flicker_step = 70;
        green_idle = 40;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_patterns();
        test_extreme_settings();
        idle_pct = 0;
        test_random_frames(150);
        idle_pct = 22;
        test_random_settings();
        drain_pipeline();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
